>>> hdl/prlt_pkg.sv
package prlt_pkg;

    // Field widths
    localparam int SEQ_W  = 32;
    localparam int TIME_W = 48;
    localparam int ID_W   = 32;
    localparam int CNT_W  = 32;

    // Default depth of the send-time history
    localparam int HISTORY_DEPTH_DEF = 64;

    // Item commands
    typedef enum logic [1:0] {
        CMD_SEND    = 2'd0,
        CMD_REPLY   = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } prlt_cmd_t;

    // Control sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } prlt_state_t;

    // Input item
    typedef struct packed {
        logic [1:0]        command;
        logic [TIME_W-1:0] now_time;
        logic [SEQ_W-1:0]  reply_seq;
        logic [ID_W-1:0]   reply_origin;
    } prlt_in_t;

    // Result item
    typedef struct packed {
        logic [SEQ_W-1:0]        tx_seq;
        logic                    reply_accepted;
        logic [TIME_W-1:0]       round_trip;
        logic                    round_trip_valid;
        logic signed [CNT_W-1:0] loss_total;
        logic [CNT_W-1:0]        late_total;
        logic [CNT_W-1:0]        reply_total;
        logic [CNT_W-1:0]        sent_total;
    } prlt_out_t;

endpackage

>>> hdl/ping_rtt_loss_tracker.sv
// Channel   Signals                          Direction  Contents
// in        in_valid, in_ready, in_data      in         command, time, reply fields
// out       out_valid, out_ready, out_data   out        one result per item
// cfg       cfg_valid, cfg_ready, cfg_data   in         originator id
//
// For each item the accept cycle issues the send-time RAM read; the execute
// cycle computes the result and writes it into the output register.
// The single-port-per-direction RAM and the shared sequence counters hold one
// item in flight. Execute waits while the output is full and out_ready is low.
// Reset clears all counters and the sequence numbers; the RAM is not cleared.
// The config write is always ready.
module ping_rtt_loss_tracker #(
    parameter int HISTORY_DEPTH = prlt_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  prlt_pkg::prlt_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output prlt_pkg::prlt_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [prlt_pkg::ID_W-1:0] cfg_data
);

    import prlt_pkg::*;

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SW = AW + 2;
    localparam logic [SEQ_W-1:0] DEPTH_SEQ  = SEQ_W'(HISTORY_DEPTH);
    localparam logic [SW-1:0]    DEPTH_S    = SW'(HISTORY_DEPTH);
    localparam logic [AW-1:0]    LAST_SLOT  = AW'(HISTORY_DEPTH - 1);

    prlt_state_t       state_reg, state_next;
    prlt_in_t          item_reg;
    logic              age_ok_reg;
    logic [ID_W-1:0]   origin_id_reg;
    logic [SEQ_W-1:0]  next_seq_reg, next_seq_next;
    logic [SEQ_W-1:0]  expected_seq_reg, expected_seq_next;
    logic [AW-1:0]     next_slot_reg, next_slot_next;
    logic [CNT_W-1:0]  loss_reg, loss_next;
    logic [CNT_W-1:0]  late_reg, late_next;
    logic [CNT_W-1:0]  reply_reg, reply_next;
    logic [CNT_W-1:0]  sent_reg, sent_next;
    logic              out_valid_reg, out_valid_next;
    prlt_out_t         out_data_reg, out_data_next;

    logic              accept;
    logic              go;
    logic [SEQ_W-1:0]  age;
    logic              age_ok;
    logic [SW-1:0]     slot_sum;
    logic [AW-1:0]     rd_slot;
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [TIME_W-1:0] ram_rd_data;
    logic [TIME_W-1:0] rtt;
    logic              matched;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Ring slot of the reply: next slot stepped back by its age
    assign age      = next_seq_reg - in_data.reply_seq;
    assign age_ok   = (age != '0) && (age <= DEPTH_SEQ);
    assign slot_sum = SW'(next_slot_reg) + DEPTH_S - SW'(age[AW:0]);
    assign rd_slot  = (slot_sum >= DEPTH_S) ? AW'(slot_sum - DEPTH_S) : AW'(slot_sum);

    // Read in the accept cycle, write in the execute cycle: never both at once
    assign ram_rd_en = accept && (in_data.command == CMD_REPLY) && age_ok;
    assign go        = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign ram_wr_en = go && (item_reg.command == CMD_SEND);

    prlt_ram #(
        .WIDTH (TIME_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_send_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (next_slot_reg),
        .wr_data (item_reg.now_time),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_slot),
        .rd_data (ram_rd_data)
    );

    assign matched = (item_reg.reply_origin == origin_id_reg);
    assign rtt     = age_ok_reg ? (item_reg.now_time - ram_rd_data) : '0;

    // Execute: counters, sequence numbers and the result
    always_comb
    begin
        state_next        = state_reg;
        next_seq_next     = next_seq_reg;
        expected_seq_next = expected_seq_reg;
        next_slot_next    = next_slot_reg;
        loss_next         = loss_reg;
        late_next         = late_reg;
        reply_next        = reply_reg;
        sent_next         = sent_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_data_next     = out_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (go)
                begin
                    out_data_next = '0;
                    case (prlt_cmd_t'(item_reg.command))
                        CMD_SEND:
                        begin
                            out_data_next.tx_seq = next_seq_reg;
                            next_seq_next = next_seq_reg + 1'b1;
                            sent_next     = sent_reg + 1'b1;
                            // slot follows next_seq % depth, also across the 2^32 wrap
                            if ((next_seq_reg == '1) || (next_slot_reg == LAST_SLOT))
                            begin
                                next_slot_next = '0;
                            end
                            else
                            begin
                                next_slot_next = next_slot_reg + 1'b1;
                            end
                        end
                        CMD_REPLY:
                        begin
                            if (matched)
                            begin
                                out_data_next.reply_accepted   = 1'b1;
                                out_data_next.round_trip       = rtt;
                                out_data_next.round_trip_valid = (rtt != '0);
                                reply_next = reply_reg + 1'b1;
                                if (item_reg.reply_seq == expected_seq_reg)
                                begin
                                    expected_seq_next = expected_seq_reg + 1'b1;
                                end
                                else if (item_reg.reply_seq > expected_seq_reg)
                                begin
                                    loss_next = loss_reg
                                              + (item_reg.reply_seq - expected_seq_reg);
                                    expected_seq_next = item_reg.reply_seq + 1'b1;
                                end
                                else
                                begin
                                    late_next = late_reg + 1'b1;
                                    loss_next = loss_reg - 1'b1;
                                end
                            end
                        end
                        CMD_RESTART:
                        begin
                            next_seq_next     = '0;
                            expected_seq_next = '0;
                            next_slot_next    = '0;
                            sent_next         = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    out_data_next.loss_total  = loss_next;
                    out_data_next.late_total  = late_next;
                    out_data_next.reply_total = reply_next;
                    out_data_next.sent_total  = sent_next;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            origin_id_reg    <= '0;
            next_seq_reg     <= '0;
            expected_seq_reg <= '0;
            next_slot_reg    <= '0;
            loss_reg         <= '0;
            late_reg         <= '0;
            reply_reg        <= '0;
            sent_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            next_seq_reg     <= next_seq_next;
            expected_seq_reg <= expected_seq_next;
            next_slot_reg    <= next_slot_next;
            loss_reg         <= loss_next;
            late_reg         <= late_next;
            reply_reg        <= reply_next;
            sent_reg         <= sent_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                origin_id_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= in_data;
            age_ok_reg <= age_ok;
        end
        out_data_reg <= out_data_next;
    end

    // Checks
    a_no_ram_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_wr_en && ram_rd_en))
        else $error("send ring read and write in the same cycle");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        SW'(next_slot_reg) < DEPTH_S)
        else $error("next ring slot beyond history depth");

    a_rtt_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.round_trip_valid |-> out_data_reg.reply_accepted)
        else $error("round trip reported for an unaccepted reply");

    a_send_advances: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |=> (next_seq_reg == $past(next_seq_reg) + 1'b1)
                      && (out_data_reg.tx_seq == $past(next_seq_reg)))
        else $error("send did not advance the sequence number");

endmodule

>>> hdl/prlt_ram.sv
module prlt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
